// ===== sv/ptfp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptfp_pkg
// Shared types, sizes and helpers for the per-type FIFO pool.
// ----------------------------------------------------------------------------
package ptfp_pkg;

    // Pool geometry.
    localparam int NUM_TYPES    = 8;
    localparam int QUEUE_DEPTH  = 16;
    localparam int HANDLE_WIDTH = 32;

    localparam int TIDX_W    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int QIDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W    = TIDX_W + QIDX_W;
    localparam int MEM_DEPTH = NUM_TYPES << QIDX_W;
    localparam int MASK_N    = (NUM_TYPES < 8) ? NUM_TYPES : 8;

    // Request command codes.
    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_POP_ANY = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_e_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } status_e_t;

    // One request.
    typedef struct packed {
        cmd_e_t      command;
        logic [2:0]  task_type;
        logic [31:0] context_handle;
    } in_item_t;

    // One result.
    typedef struct packed {
        status_e_t   status;
        logic [2:0]  served_type;
        logic [31:0] handle_out;
        logic [31:0] active_count;
        logic [31:0] total_count;
        logic [7:0]  nonempty_mask;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;
        logic exec;
        logic load_out;
    } ctl_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } sts_t;

    // Advance a ring index, wrapping at the queue depth.
    function automatic logic [QIDX_W-1:0] wrap_next(input logic [QIDX_W-1:0] idx);
        logic [QIDX_W-1:0] nxt;
        nxt = idx + 1'b1;
        if (32'(idx) == QUEUE_DEPTH - 1) begin
            nxt = '0;
        end
        return nxt;
    endfunction

endpackage

// ===== sv/ptfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptfp_ctrl
// Sequencer: takes a request, runs it through the datapath, hands the result
// to the output register.
// ----------------------------------------------------------------------------
module ptfp_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ptfp_pkg::sts_t sts,
    output ptfp_pkg::ctl_t ctl
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next-state logic.
    always_comb begin
        state_next   = state_reg;
        ctl.accept   = 1'b0;
        ctl.exec     = 1'b0;
        ctl.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ctl.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/ptfp_datapath.sv =====
// ----------------------------------------------------------------------------
// ptfp_datapath
// Queue pointers, fill levels, counters, handle memory and output register.
// ----------------------------------------------------------------------------
module ptfp_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  ptfp_pkg::in_item_t  s_item,
    input  logic                m_ready,
    output logic                m_valid,
    output ptfp_pkg::out_item_t m_item,
    input  ptfp_pkg::ctl_t      ctl,
    output ptfp_pkg::sts_t      sts
);

    // Latched request.
    ptfp_pkg::cmd_e_t                  cmd_reg;
    logic [2:0]                        type_reg;
    logic [ptfp_pkg::HANDLE_WIDTH-1:0] handle_reg;

    // Per-type queue state.
    logic [ptfp_pkg::QIDX_W-1:0] head_reg [ptfp_pkg::NUM_TYPES];
    logic [ptfp_pkg::QIDX_W-1:0] head_next[ptfp_pkg::NUM_TYPES];
    logic [ptfp_pkg::QIDX_W-1:0] tail_reg [ptfp_pkg::NUM_TYPES];
    logic [ptfp_pkg::QIDX_W-1:0] tail_next[ptfp_pkg::NUM_TYPES];
    logic [ptfp_pkg::FILL_W-1:0] fill_reg [ptfp_pkg::NUM_TYPES];
    logic [ptfp_pkg::FILL_W-1:0] fill_next[ptfp_pkg::NUM_TYPES];

    logic [31:0] pushed_reg, pushed_next;
    logic [31:0] popped_reg, popped_next;

    // Per-request results held until the output register is free.
    ptfp_pkg::status_e_t status_reg, status_next;
    logic [2:0]          served_reg, served_next;
    logic                hsel_reg, hsel_next;

    // Handle memory.
    logic [ptfp_pkg::HANDLE_WIDTH-1:0] mem [ptfp_pkg::MEM_DEPTH];
    logic [ptfp_pkg::HANDLE_WIDTH-1:0] rd_data_reg;

    logic                  out_valid_reg;
    ptfp_pkg::out_item_t   out_reg;

    logic [ptfp_pkg::NUM_TYPES-1:0] ne;
    logic                           any_ne;
    logic [ptfp_pkg::TIDX_W-1:0]    pick;
    logic [ptfp_pkg::TIDX_W-1:0]    sel;
    logic                           type_ok;
    logic [ptfp_pkg::FILL_W-1:0]    sel_fill;
    logic                           push_ok;
    logic                           pop_ok;
    logic                           mem_we;
    logic                           mem_re;
    logic [ptfp_pkg::ADDR_W-1:0]    mem_addr;
    logic [7:0]                     mask_c;

    // Non-empty flags and lowest non-empty type.
    always_comb begin
        pick = '0;
        for (int t = ptfp_pkg::NUM_TYPES - 1; t >= 0; t--) begin
            ne[t] = (fill_reg[t] != '0);
            if (ne[t]) begin
                pick = ptfp_pkg::TIDX_W'(t);
            end
        end
    end

    assign any_ne = |ne;

    // Mask of non-empty types as reported.
    always_comb begin
        mask_c = '0;
        for (int t = 0; t < ptfp_pkg::MASK_N; t++) begin
            mask_c[t] = ne[t];
        end
    end

    // Queue selection and the checks on it.
    assign type_ok  = (32'(type_reg) < ptfp_pkg::NUM_TYPES);
    assign sel      = (cmd_reg == ptfp_pkg::CMD_POP_ANY) ? pick
                                                         : ptfp_pkg::TIDX_W'(type_reg);
    assign sel_fill = fill_reg[sel];
    assign push_ok  = type_ok && (sel_fill < ptfp_pkg::FILL_W'(ptfp_pkg::QUEUE_DEPTH));
    assign pop_ok   = (cmd_reg == ptfp_pkg::CMD_POP_ANY) ? any_ne
                                                         : (type_ok && (sel_fill != '0));

    assign mem_we   = ctl.exec && (cmd_reg == ptfp_pkg::CMD_PUSH) && push_ok;
    assign mem_re   = ctl.exec && ((cmd_reg == ptfp_pkg::CMD_POP) ||
                                   (cmd_reg == ptfp_pkg::CMD_POP_ANY)) && pop_ok;
    assign mem_addr = (cmd_reg == ptfp_pkg::CMD_PUSH) ? {sel, tail_reg[sel]}
                                                      : {sel, head_reg[sel]};

    // Execute one request against the queue state.
    always_comb begin
        for (int t = 0; t < ptfp_pkg::NUM_TYPES; t++) begin
            head_next[t] = head_reg[t];
            tail_next[t] = tail_reg[t];
            fill_next[t] = fill_reg[t];
        end
        pushed_next = pushed_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        served_next = served_reg;
        hsel_next   = hsel_reg;
        if (ctl.exec) begin
            unique case (cmd_reg)
                ptfp_pkg::CMD_PUSH: begin
                    served_next = type_reg;
                    hsel_next   = 1'b0;
                    if (push_ok) begin
                        status_next    = ptfp_pkg::STS_OK;
                        tail_next[sel] = ptfp_pkg::wrap_next(tail_reg[sel]);
                        fill_next[sel] = sel_fill + 1'b1;
                        pushed_next    = pushed_reg + 32'd1;
                    end else begin
                        status_next = ptfp_pkg::STS_FULL;
                    end
                end
                ptfp_pkg::CMD_POP,
                ptfp_pkg::CMD_POP_ANY: begin
                    if (cmd_reg == ptfp_pkg::CMD_POP) begin
                        served_next = type_reg;
                    end else begin
                        served_next = any_ne ? 3'(pick) : 3'd0;
                    end
                    hsel_next = pop_ok;
                    if (pop_ok) begin
                        status_next    = ptfp_pkg::STS_OK;
                        head_next[sel] = ptfp_pkg::wrap_next(head_reg[sel]);
                        fill_next[sel] = sel_fill - 1'b1;
                        popped_next    = popped_reg + 32'd1;
                    end else begin
                        status_next = ptfp_pkg::STS_EMPTY;
                    end
                end
                ptfp_pkg::CMD_CLEAR: begin
                    status_next = ptfp_pkg::STS_OK;
                    served_next = 3'd0;
                    hsel_next   = 1'b0;
                    for (int t = 0; t < ptfp_pkg::NUM_TYPES; t++) begin
                        head_next[t] = '0;
                        tail_next[t] = '0;
                        fill_next[t] = '0;
                    end
                end
                default: begin
                    hsel_next = 1'b0;
                end
            endcase
        end
    end

    // Control state: pointers, fill levels, counters, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < ptfp_pkg::NUM_TYPES; t++) begin
                head_reg[t] <= '0;
                tail_reg[t] <= '0;
                fill_reg[t] <= '0;
            end
            pushed_reg    <= '0;
            popped_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            for (int t = 0; t < ptfp_pkg::NUM_TYPES; t++) begin
                head_reg[t] <= head_next[t];
                tail_reg[t] <= tail_next[t];
                fill_reg[t] <= fill_next[t];
            end
            pushed_reg <= pushed_next;
            popped_reg <= popped_next;
            if (ctl.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: latched request, per-request result, output item.
    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            cmd_reg    <= s_item.command;
            type_reg   <= s_item.task_type;
            handle_reg <= ptfp_pkg::HANDLE_WIDTH'(s_item.context_handle);
        end
        status_reg <= status_next;
        served_reg <= served_next;
        hsel_reg   <= hsel_next;
        if (ctl.load_out) begin
            out_reg.status        <= status_reg;
            out_reg.served_type   <= served_reg;
            out_reg.handle_out    <= hsel_reg ? 32'(rd_data_reg) : 32'd0;
            out_reg.active_count  <= popped_reg;
            out_reg.total_count   <= pushed_reg;
            out_reg.nonempty_mask <= mask_c;
        end
    end

    // Handle memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= handle_reg;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_item       = out_reg;
    assign sts.out_free = !out_valid_reg || m_ready;

endmodule

// ===== sv/per_type_fifo_pool.sv =====
// ----------------------------------------------------------------------------
// per_type_fifo_pool
// One FIFO of task handles per task type, with push, pop by type, pop of the
// lowest-numbered non-empty type, and clear.
// ----------------------------------------------------------------------------
// Each request goes from acceptance to a loaded result in order: it is
// latched, then the selected queue is updated and the handle memory (a
// single-port array with a registered read) is read or written, then the
// output register is loaded. The next request is accepted in the cycle
// after the result is loaded. A result waiting on m_ready holds off only
// the loading of the following result, not its acceptance. No clearing pass
// follows reset; queue pointers and counters reset to zero.
module per_type_fifo_pool (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ptfp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ptfp_pkg::out_item_t m_item
);

    ptfp_pkg::ctl_t ctl;
    ptfp_pkg::sts_t sts;

    // Sequencer.
    ptfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // Queue state, memory and output register.
    ptfp_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item),
        .ctl     (ctl),
        .sts     (sts)
    );

endmodule

// ===== sv/ptfp_checker.sv =====
// ----------------------------------------------------------------------------
// ptfp_checker
// Port-level checks for the per-type FIFO pool, bound to the top level.
// ----------------------------------------------------------------------------
module ptfp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ptfp_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input ptfp_pkg::out_item_t m_item
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // A failed request never returns a handle.
    a_fail_no_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status != ptfp_pkg::STS_OK) |-> m_item.handle_out == 32'd0)
        else $error("handle returned on a failed request");

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in progress");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind per_type_fifo_pool ptfp_checker u_ptfp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ===== test/per_type_fifo_pool_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_type_fifo_pool_tb
// Self-checking bench for the per-type FIFO pool. A queue of requests, with a
// short directed opening and then randomized traffic phases, feeds a bursty
// driver. A stalling monitor compares each result, field by field, with the
// result that a behavioral copy of the pool predicted when the request was
// accepted.
// ----------------------------------------------------------------------------
module per_type_fifo_pool_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_COUNT = 1200;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 40;
    localparam logic [31:0] HANDLE_KEEP =
        (ptfp_pkg::HANDLE_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                         ((32'd1 << ptfp_pkg::HANDLE_WIDTH) - 32'd1);

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ptfp_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ptfp_pkg::out_item_t m_item;

    // Requests waiting to be driven and results waiting to be seen.
    ptfp_pkg::in_item_t  pending_requests[$];
    ptfp_pkg::out_item_t expected_results[$];

    // Behavioral copy of the pool contents and counters.
    logic [31:0] slot_handle [ptfp_pkg::NUM_TYPES][ptfp_pkg::QUEUE_DEPTH];
    int          rd_ptr      [ptfp_pkg::NUM_TYPES];
    int          wr_ptr      [ptfp_pkg::NUM_TYPES];
    int          occupancy   [ptfp_pkg::NUM_TYPES];
    logic [31:0] accepted_pushes = '0;
    logic [31:0] served_pops     = '0;

    int mismatch_count = 0;
    int result_index   = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int pattern_age    = 0;
    logic [15:0] stall_pattern = '1;

    per_type_fifo_pool dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Print one mismatch line, up to a cap, and count every one.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic add_request(input ptfp_pkg::cmd_e_t cmd, input int typ,
                               input logic [31:0] hnd);
        ptfp_pkg::in_item_t req;
        req.command        = cmd;
        req.task_type      = 3'(typ);
        req.context_handle = hnd;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // Remove the oldest handle of one type and count the pop.
    function automatic logic [31:0] take_oldest(input int t);
        logic [31:0] hnd;
        hnd = slot_handle[t][rd_ptr[t]];
        rd_ptr[t] = (rd_ptr[t] + 1) % ptfp_pkg::QUEUE_DEPTH;
        occupancy[t]--;
        served_pops++;
        return hnd;
    endfunction

    // Apply one request to the pool copy and return the result it should give.
    function automatic ptfp_pkg::out_item_t predict_pool_result(input ptfp_pkg::in_item_t req);
        ptfp_pkg::out_item_t res;
        int t;
        int sel;
        res = '0;
        res.status = ptfp_pkg::STS_OK;
        t = int'(req.task_type);
        case (req.command)
            ptfp_pkg::CMD_PUSH: begin
                res.served_type = req.task_type;
                if (t >= ptfp_pkg::NUM_TYPES || occupancy[t] >= ptfp_pkg::QUEUE_DEPTH) begin
                    res.status = ptfp_pkg::STS_FULL;
                end else begin
                    slot_handle[t][wr_ptr[t]] = req.context_handle & HANDLE_KEEP;
                    wr_ptr[t] = (wr_ptr[t] + 1) % ptfp_pkg::QUEUE_DEPTH;
                    occupancy[t]++;
                    accepted_pushes++;
                end
            end
            ptfp_pkg::CMD_POP: begin
                res.served_type = req.task_type;
                if (t >= ptfp_pkg::NUM_TYPES || occupancy[t] == 0) begin
                    res.status = ptfp_pkg::STS_EMPTY;
                end else begin
                    res.handle_out = take_oldest(t);
                end
            end
            ptfp_pkg::CMD_POP_ANY: begin
                // The lowest-numbered type that holds anything wins.
                sel = -1;
                for (int i = ptfp_pkg::NUM_TYPES - 1; i >= 0; i--) begin
                    if (occupancy[i] != 0) begin
                        sel = i;
                    end
                end
                if (sel < 0) begin
                    res.status = ptfp_pkg::STS_EMPTY;
                end else begin
                    res.served_type = 3'(sel);
                    res.handle_out  = take_oldest(sel);
                end
            end
            default: begin
                // Clear empties every queue but leaves the counters alone.
                for (int i = 0; i < ptfp_pkg::NUM_TYPES; i++) begin
                    rd_ptr[i]    = 0;
                    wr_ptr[i]    = 0;
                    occupancy[i] = 0;
                end
            end
        endcase
        res.active_count = served_pops;
        res.total_count  = accepted_pushes;
        for (int i = 0; i < ptfp_pkg::MASK_N; i++) begin
            res.nonempty_mask[i] = (occupancy[i] != 0);
        end
        return res;
    endfunction

    // Driver: sends queued requests in bursts with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_item  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(),
                                        predict_pool_result(s_item));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    s_valid <= 1'b1;
                    s_item  <= pending_requests[0];
                    pending_requests.delete(0);
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result taken and stalls on a rotating pattern
    // that is reloaded with a new random pattern whenever pattern_age wraps.
    always @(posedge aclk) begin
        ptfp_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              result_index));
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (m_item.status !== want.status)
                        report_mismatch($sformatf("result %0d status got %0d want %0d",
                                        result_index, m_item.status, want.status));
                    if (m_item.served_type !== want.served_type)
                        report_mismatch($sformatf("result %0d served_type got %0d want %0d",
                                        result_index, m_item.served_type, want.served_type));
                    if (m_item.handle_out !== want.handle_out)
                        report_mismatch($sformatf("result %0d handle_out got %h want %h",
                                        result_index, m_item.handle_out, want.handle_out));
                    if (m_item.active_count !== want.active_count)
                        report_mismatch($sformatf("result %0d active_count got %0d want %0d",
                                        result_index, m_item.active_count, want.active_count));
                    if (m_item.total_count !== want.total_count)
                        report_mismatch($sformatf("result %0d total_count got %0d want %0d",
                                        result_index, m_item.total_count, want.total_count));
                    if (m_item.nonempty_mask !== want.nonempty_mask)
                        report_mismatch($sformatf("result %0d nonempty_mask got %b want %b",
                                        result_index, m_item.nonempty_mask,
                                        want.nonempty_mask));
                end
                result_index++;
            end
            m_ready <= stall_pattern[0];
            if (pattern_age == 15) begin
                pattern_age <= 0;
                case ($urandom_range(0, 3))
                    0:       stall_pattern <= '1;
                    1:       stall_pattern <= 16'($urandom);
                    2:       stall_pattern <= 16'($urandom) | 16'($urandom);
                    default: stall_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
                endcase
            end else begin
                pattern_age   <= pattern_age + 1;
                stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) begin
            @(posedge aclk);
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int seg_left;
        int seg_mode;
        int lo;
        int hi;
        int pick;
        int push_pct;
        int pop_pct;
        int typ;
        seg_left = 0;
        seg_mode = 0;
        lo = 0;
        hi = ptfp_pkg::NUM_TYPES - 1;

        // Directed opening: empty pops, handle extremes, clear, overflow.
        add_request(ptfp_pkg::CMD_POP_ANY, 0, 32'h0);
        add_request(ptfp_pkg::CMD_POP, 7, 32'hFFFF_FFFF);
        add_request(ptfp_pkg::CMD_PUSH, 0, 32'h0000_0000);
        add_request(ptfp_pkg::CMD_PUSH, 7, 32'hFFFF_FFFF);
        add_request(ptfp_pkg::CMD_POP, 7, 32'h0);
        add_request(ptfp_pkg::CMD_CLEAR, 5, 32'h1234_5678);
        add_request(ptfp_pkg::CMD_POP, 0, 32'h0);
        add_request(ptfp_pkg::CMD_POP_ANY, 3, 32'h0);
        for (int i = 0; i < ptfp_pkg::QUEUE_DEPTH + 1; i++) begin
            add_request(ptfp_pkg::CMD_PUSH, 2, $urandom);
        end

        // Random phases that lean toward filling, draining or neither, over
        // either every type or a pair of neighboring types.
        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 80);
                seg_mode = $urandom_range(0, 2);
                if ($urandom_range(0, 1) == 0) begin
                    lo = 0;
                    hi = 7;
                end else begin
                    lo = $urandom_range(0, 6);
                    hi = lo + 1;
                end
            end
            seg_left--;
            case (seg_mode)
                0: begin
                    push_pct = 65;
                    pop_pct  = 20;
                end
                1: begin
                    push_pct = 25;
                    pop_pct  = 45;
                end
                default: begin
                    push_pct = 45;
                    pop_pct  = 30;
                end
            endcase
            typ  = ($urandom_range(0, 9) < 8) ? $urandom_range(lo, hi) : $urandom_range(0, 7);
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                add_request(ptfp_pkg::CMD_CLEAR, typ, $urandom);
            end else if (pick < 2 + push_pct) begin
                add_request(ptfp_pkg::CMD_PUSH, typ, $urandom);
            end else if (pick < 2 + push_pct + pop_pct) begin
                add_request(ptfp_pkg::CMD_POP, typ, $urandom);
            end else begin
                add_request(ptfp_pkg::CMD_POP_ANY, typ, $urandom);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every request has been sent and answered. Sampling at
        // the falling edge sees the settled state of the driver and monitor.
        @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
